/* rtl/bbp_pkg.sv */
// shared types and constants for the bicubic bezier patch evaluator
// no dependencies; imported by every module of the block
package bbp_pkg;

    localparam int NUM_LANES = 3;
    localparam int COORD_W   = 32;
    localparam int STEP_W    = 7;
    localparam int SLOT_W    = 4;
    localparam int NUM_SLOTS = 16;
    // weights and r^3 never exceed 64^3
    localparam int WGT_W     = 19;
    // squares of 7-bit values
    localparam int SQ_W      = 13;
    // accumulator of four weighted terms
    localparam int ACC_W     = 52;
    // unsigned quotient bits produced by the divider
    localparam int QUO_W     = 34;
    // stored row sums, signed
    localparam int Q_W       = 34;

    localparam logic [STEP_W-1:0] RES_MAX   = 7'd64;
    localparam logic [STEP_W-1:0] RES_MIN   = 7'd1;
    localparam logic [STEP_W-1:0] RES_RESET = 7'd8;

    // action codes carried in tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef logic [WGT_W-1:0] wgt_t;
    typedef wgt_t [3:0] wvec_t;

    // control from the top level to each coordinate lane
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic              start;
    } lane_ctl_t;

endpackage

/* rtl/bbp_weights.sv */
// bernstein weight unit: clamps resolution and steps, forms the integer
// weights for u and v and the denominator r^3 over two registered stages
// depends on bbp_pkg
module bbp_weights (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bbp_pkg::STEP_W-1:0] res_cfg,
    input  logic [bbp_pkg::STEP_W-1:0] step_u,
    input  logic [bbp_pkg::STEP_W-1:0] step_v,
    output logic                       done,
    output bbp_pkg::wvec_t             wu,
    output bbp_pkg::wvec_t             wv,
    output bbp_pkg::wgt_t              den
);
    import bbp_pkg::*;

    logic [STEP_W-1:0] r_eff;
    logic [STEP_W-1:0] i_c;
    logic [STEP_W-1:0] j_c;

    logic              v1_reg;
    logic              v2_reg;
    logic [STEP_W-1:0] ti_reg;
    logic [STEP_W-1:0] tj_reg;
    logic [STEP_W-1:0] su_reg;
    logic [STEP_W-1:0] sv_reg;
    logic [STEP_W-1:0] r_reg;
    logic [SQ_W-1:0]   i2_reg;
    logic [SQ_W-1:0]   j2_reg;
    logic [SQ_W-1:0]   s2u_reg;
    logic [SQ_W-1:0]   s2v_reg;
    logic [SQ_W-1:0]   r2_reg;
    wvec_t             wu_reg;
    wvec_t             wv_reg;
    wgt_t              den_reg;

    // square times a 7-bit value, optionally times three
    function automatic wgt_t wmul(input logic [SQ_W-1:0] a, input logic [STEP_W-1:0] b,
                                  input logic x3);
        logic [SQ_W+STEP_W+1:0] p;
        begin
            p = (SQ_W+STEP_W+2)'(a) * (SQ_W+STEP_W+2)'(b);
            if (x3)
            begin
                p = p + (p << 1);
            end
            return p[WGT_W-1:0];
        end
    endfunction

    // clamp resolution and steps
    always_comb
    begin
        if (res_cfg == '0)
        begin
            r_eff = RES_MIN;
        end
        else if (res_cfg > RES_MAX)
        begin
            r_eff = RES_MAX;
        end
        else
        begin
            r_eff = res_cfg;
        end
        i_c = (step_u > r_eff) ? r_eff : step_u;
        j_c = (step_v > r_eff) ? r_eff : step_v;
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    // stage one: squares
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ti_reg  <= i_c;
            tj_reg  <= j_c;
            su_reg  <= r_eff - i_c;
            sv_reg  <= r_eff - j_c;
            r_reg   <= r_eff;
            i2_reg  <= SQ_W'(i_c) * SQ_W'(i_c);
            j2_reg  <= SQ_W'(j_c) * SQ_W'(j_c);
            s2u_reg <= SQ_W'(r_eff - i_c) * SQ_W'(r_eff - i_c);
            s2v_reg <= SQ_W'(r_eff - j_c) * SQ_W'(r_eff - j_c);
            r2_reg  <= SQ_W'(r_eff) * SQ_W'(r_eff);
        end
    end

    // stage two: cubic weights and r^3
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            wu_reg[0] <= wmul(s2u_reg, su_reg, 1'b0);
            wu_reg[1] <= wmul(s2u_reg, ti_reg, 1'b1);
            wu_reg[2] <= wmul(i2_reg, su_reg, 1'b1);
            wu_reg[3] <= wmul(i2_reg, ti_reg, 1'b0);
            wv_reg[0] <= wmul(s2v_reg, sv_reg, 1'b0);
            wv_reg[1] <= wmul(s2v_reg, tj_reg, 1'b1);
            wv_reg[2] <= wmul(j2_reg, sv_reg, 1'b1);
            wv_reg[3] <= wmul(j2_reg, tj_reg, 1'b0);
            den_reg   <= wmul(r2_reg, r_reg, 1'b0);
        end
    end

    assign done = v2_reg;
    assign wu   = wu_reg;
    assign wv   = wv_reg;
    assign den  = den_reg;

endmodule

/* rtl/bbp_rdiv.sv */
// sequential rounding divider: floor(num/den + 1/2) for den > 0,
// one quotient bit per cycle, restoring form
// depends on bbp_pkg
module bbp_rdiv (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [bbp_pkg::ACC_W-1:0] num,
    input  bbp_pkg::wgt_t                    den,
    output logic                             done,
    output logic signed [bbp_pkg::QUO_W:0]   quot
);
    import bbp_pkg::*;

    localparam int MW    = ACC_W + 1;
    localparam int CNT_W = $clog2(QUO_W);

    logic [MW-1:0]          m_val;
    logic [MW-1:0]          d_ext;
    logic                   neg_now;
    logic [MW-1:0]          mag;
    logic                   ge;
    logic [QUO_W-1:0]       q_next;

    logic                   busy_reg;
    logic                   done_reg;
    logic                   neg_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [MW-1:0]          rem_reg;
    logic [MW-1:0]          ds_reg;
    logic [QUO_W-1:0]       q_reg;
    logic signed [QUO_W:0]  quot_reg;

    // bias by half the divisor, fold negatives onto a ceiling division
    always_comb
    begin
        d_ext   = MW'(den);
        m_val   = {num[ACC_W-1], num} + MW'(den >> 1);
        neg_now = m_val[MW-1];
        mag     = neg_now ? (~m_val + d_ext) : m_val;
        ge      = (rem_reg >= ds_reg);
        q_next  = {q_reg[QUO_W-2:0], ge};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= neg_now;
            rem_reg <= mag;
            ds_reg  <= d_ext << (QUO_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - ds_reg;
            end
            ds_reg <= ds_reg >> 1;
            q_reg  <= q_next;
            if (cnt_reg == '0)
            begin
                quot_reg <= neg_reg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/bbp_lane.sv */
// one coordinate lane: holds the 16 control point values of its coordinate,
// accumulates row sums and the column sum through one multiplier and one divider
// depends on bbp_pkg, bbp_rdiv
module bbp_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bbp_pkg::lane_ctl_t                ctl,
    input  logic [bbp_pkg::COORD_W-1:0]       wr_data,
    input  bbp_pkg::wvec_t                    wu,
    input  bbp_pkg::wvec_t                    wv,
    input  bbp_pkg::wgt_t                     den,
    output logic                              done,
    output logic signed [bbp_pkg::COORD_W-1:0] result
);
    import bbp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC1  = 3'd1;
    localparam logic [2:0] ST_DIV1  = 3'd2;
    localparam logic [2:0] ST_WAIT1 = 3'd3;
    localparam logic [2:0] ST_MAC2  = 3'd4;
    localparam logic [2:0] ST_DIV2  = 3'd5;
    localparam logic [2:0] ST_WAIT2 = 3'd6;

    localparam logic signed [QUO_W:0] SAT_HI = (QUO_W+1)'(64'sh7FFF_FFFF);
    localparam logic signed [QUO_W:0] SAT_LO = -(QUO_W+1)'(64'sh8000_0000);

    logic [COORD_W-1:0]           pt_reg [NUM_SLOTS];
    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic [1:0]                   row_reg;
    logic [1:0]                   k_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [Q_W-1:0]        q_reg [4];
    logic signed [COORD_W-1:0]    result_reg;
    logic                         done_reg;

    logic signed [WGT_W:0]        w_s;
    logic signed [Q_W-1:0]        x_s;
    logic signed [WGT_W+Q_W:0]    prod;
    logic signed [ACC_W-1:0]      acc_add;
    logic [COORD_W-1:0]           pt_sel;
    logic                         div_start;
    logic                         div_done;
    logic signed [QUO_W:0]        div_quot;

    // multiply-accumulate operand select
    always_comb
    begin
        pt_sel = pt_reg[{row_reg, k_reg}];
        if (state_reg == ST_MAC1)
        begin
            w_s = $signed({1'b0, wu[k_reg]});
            x_s = $signed({{(Q_W-COORD_W){pt_sel[COORD_W-1]}}, pt_sel});
        end
        else
        begin
            w_s = $signed({1'b0, wv[k_reg]});
            x_s = q_reg[k_reg];
        end
        prod    = w_s * x_s;
        acc_add = acc_reg + prod[ACC_W-1:0];
    end

    assign div_start = (state_reg == ST_DIV1) || (state_reg == ST_DIV2);

    bbp_rdiv u_rdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_reg),
        .den   (den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = ST_MAC1;
                end
            end
            ST_MAC1:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                state_next = ST_WAIT1;
            end
            ST_WAIT1:
            begin
                if (div_done)
                begin
                    state_next = (row_reg == 2'd3) ? ST_MAC2 : ST_MAC1;
                end
            end
            ST_MAC2:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                state_next = ST_WAIT2;
            end
            ST_WAIT2:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control point store, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                pt_reg[s] <= '0;
            end
        end
        else if (ctl.wr_en)
        begin
            pt_reg[ctl.wr_slot] <= wr_data;
        end
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            row_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_WAIT2) && div_done;
            case (state_reg)
                ST_IDLE:
                begin
                    row_reg <= '0;
                    k_reg   <= '0;
                end
                ST_MAC1, ST_MAC2:
                begin
                    k_reg <= k_reg + 1'b1;
                end
                ST_WAIT1:
                begin
                    if (div_done)
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // accumulator, row sums and result
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                acc_reg <= '0;
            end
            ST_MAC1, ST_MAC2:
            begin
                acc_reg <= acc_add;
            end
            ST_WAIT1:
            begin
                if (div_done)
                begin
                    q_reg[row_reg] <= div_quot[Q_W-1:0];
                    acc_reg        <= '0;
                end
            end
            ST_WAIT2:
            begin
                if (div_done)
                begin
                    if (div_quot > SAT_HI)
                    begin
                        result_reg <= SAT_HI[COORD_W-1:0];
                    end
                    else if (div_quot < SAT_LO)
                    begin
                        result_reg <= SAT_LO[COORD_W-1:0];
                    end
                    else
                    begin
                        result_reg <= div_quot[COORD_W-1:0];
                    end
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/bicubic_bezier_patch_eval_core.sv */
// top level of the bicubic bezier patch evaluator: stream ports, resolution
// register, weight unit, three coordinate lanes and the output register
// depends on bbp_pkg, bbp_weights, bbp_lane, bbp_rdiv

// A load beat (tuser low) writes one control point into all three lanes in the
// same cycle and gives no result. An evaluate beat (tuser high) passes through
// the registered stages of the weight unit, then starts the lanes, which form
// four row sums and one column sum, each by a multiply-accumulate over four
// weighted terms, a divider start and a rounding division by r^3 to a 34-bit
// quotient ending in its done flag. The lane done flags then set the pending
// flag, and the lane results move into the output register once it is free.
// The per-lane divider is the slowest part. The three lanes run in lockstep, one
// per coordinate. One evaluate is in flight at a time; the next beat can be accepted
// once its result is in the output register, and the result sits there meanwhile.
module bicubic_bezier_patch_eval_core (
    input  logic         clk,
    input  logic         rst_n,
    // config: grid_resolution
    input  logic         cfg_wr_en,
    input  logic [6:0]   cfg_wr_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_slot[3:0], coord_x[35:4], coord_y[67:36], coord_z[99:68],
    // step_u[106:100], step_v[113:107], zero fill [119:114]
    input  logic [119:0] s_tdata,
    // action[0]
    input  logic         s_tuser,
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // surf_x[31:0], surf_y[63:32], surf_z[95:64]
    output logic [95:0]  m_tdata
);
    import bbp_pkg::*;

    logic [STEP_W-1:0]        res_cfg_reg;
    logic                     busy_reg;
    logic                     pend_reg;
    logic                     out_valid_reg;
    logic [95:0]              out_data_reg;

    logic                     accept;
    logic                     is_eval;
    logic                     take;
    logic                     wt_done;
    wvec_t                    wu;
    wvec_t                    wv;
    wgt_t                     den;
    lane_ctl_t                lane_ctl;
    logic [NUM_LANES-1:0]     lane_done;
    logic [COORD_W-1:0]       lane_res [NUM_LANES];

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign is_eval  = (s_tuser == ACT_EVAL);
    assign take     = pend_reg && (!out_valid_reg || m_tready);

    // resolution register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cfg_reg <= RES_RESET;
        end
        else if (cfg_wr_en)
        begin
            res_cfg_reg <= cfg_wr_data;
        end
    end

    bbp_weights u_weights (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && is_eval),
        .res_cfg (res_cfg_reg),
        .step_u  (s_tdata[106:100]),
        .step_v  (s_tdata[113:107]),
        .done    (wt_done),
        .wu      (wu),
        .wv      (wv),
        .den     (den)
    );

    // lane control
    always_comb
    begin
        lane_ctl.wr_en   = accept && (s_tuser == ACT_LOAD);
        lane_ctl.wr_slot = s_tdata[SLOT_W-1:0];
        lane_ctl.start   = wt_done;
    end

    // one lane per coordinate
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        bbp_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (lane_ctl),
            .wr_data (s_tdata[SLOT_W + COORD_W*l +: COORD_W]),
            .wu      (wu),
            .wv      (wv),
            .den     (den),
            .done    (lane_done[l]),
            .result  (lane_res[l])
        );
    end

    // busy, pending result and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && is_eval)
            begin
                busy_reg <= 1'b1;
            end
            if (&lane_done)
            begin
                pend_reg <= 1'b1;
            end
            if (take)
            begin
                pend_reg      <= 1'b0;
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // merge lane results into the output beat
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= {lane_res[2], lane_res[1], lane_res[0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/bbp_checker.sv */
// port-level checks for the bicubic bezier patch evaluator
// depends on bbp_pkg; bound to bicubic_bezier_patch_eval_core
module bbp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         cfg_wr_en,
    input logic [6:0]   cfg_wr_data,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [119:0] s_tdata,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata
);
    import bbp_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // input ready is low right after an accepted evaluate beat
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_EVAL) |=> !s_tready)
        else $error("input ready right after an evaluate beat");

    // a new result only appears at the end of an evaluate
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result beat without an evaluate in flight");

    // an accepted input beat carries known data
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !$isunknown({s_tuser, s_tdata}))
        else $error("input beat with unknown bits");

    // resolution written only while the block is idle
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |-> s_tready && !m_tvalid && !$isunknown(cfg_wr_data))
        else $error("resolution written while busy");

endmodule

bind bicubic_bezier_patch_eval_core bbp_checker u_bbp_checker (.*);
